### hdl/vrd_pkg.sv
// Package for the varint record deframer: item types, codes and sizing constants.
// Used by vrd_core and varint_record_deframer; depends on nothing.
`default_nettype none
package vrd_pkg;

   localparam int MAX_PACKET_DEF = 8192;
   localparam int BYTE_W         = 8;
   localparam int SIZE_W         = 14;
   localparam int GROUP_W        = 7;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_JUNK    = 2'd2,
      KIND_TRUNC   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_CODE    = 2'd0,
      PHASE_LENGTH  = 2'd1,
      PHASE_PAYLOAD = 2'd2,
      PHASE_DISCARD = 2'd3
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              start_of_packet;
      logic [SIZE_W-1:0] packet_length;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] record_code;
      logic [SIZE_W-1:0] record_size;
      logic [BYTE_W-1:0] payload_byte;
      logic              last_of_record;
   } rsp_type;

endpackage
`default_nettype wire

### hdl/vrd_core.sv
// Parser state and per-byte step logic of the varint record deframer.
// Depends on vrd_pkg; instantiated by varint_record_deframer.
`default_nettype none
module vrd_core #(
   parameter int MAX_PACKET = vrd_pkg::MAX_PACKET_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire vrd_pkg::req_type item,
   output logic                 res_valid,
   output vrd_pkg::rsp_type     res_item
);
   import vrd_pkg::*;

   localparam int CW = $clog2(MAX_PACKET + 2);
   localparam int WW = CW + GROUP_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET);
   localparam logic [CW-1:0] SAT_C = CW'(MAX_PACKET + 1);
   localparam logic [WW-1:0] MAX_W = WW'(MAX_PACKET);

   phase_type         phase_ff, phase_in;
   logic [CW-1:0]     bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0] code_ff, code_in;
   logic [CW-1:0]     acc_ff, acc_in;
   logic              ovf_ff, ovf_in;
   logic [CW-1:0]     pay_left_ff, pay_left_in;

   logic [CW-1:0]     start_len;
   logic [CW-1:0]     rem;
   logic [WW-1:0]     wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_CODE;
         bytes_left_ff <= '0;
         code_ff       <= '0;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         pay_left_ff   <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         code_ff       <= code_in;
         acc_ff        <= acc_in;
         ovf_ff        <= ovf_in;
         pay_left_ff   <= pay_left_in;
      end
   end

   always_comb begin
      start_len = (32'(item.packet_length) > MAX_PACKET) ? MAX_C : CW'(item.packet_length);
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      code_in       = code_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      pay_left_in   = pay_left_ff;
      res_valid     = 1'b0;
      res_item      = '0;
      rem           = '0;
      wide          = '0;

      if (item.start_of_packet) begin
         bytes_left_in = start_len;
         phase_in      = PHASE_CODE;
         acc_in        = '0;
         ovf_in        = 1'b0;
         pay_left_in   = '0;
      end

      if (bytes_left_in != '0) begin
         rem           = bytes_left_in - CW'(1);
         bytes_left_in = rem;
         case (phase_in)
            PHASE_CODE: begin
               if (rem == '0) begin
                  res_valid     = 1'b1;
                  res_item.kind = KIND_JUNK;
               end else begin
                  code_in  = item.data_byte;
                  acc_in   = '0;
                  ovf_in   = 1'b0;
                  phase_in = PHASE_LENGTH;
               end
            end
            PHASE_LENGTH: begin
               if (!ovf_in) begin
                  wide = {acc_in, item.data_byte[GROUP_W-1:0]};
                  if (wide > MAX_W) begin
                     ovf_in = 1'b1;
                     acc_in = SAT_C;
                  end else begin
                     acc_in = wide[CW-1:0];
                  end
               end
               if (!(item.data_byte[BYTE_W-1] && rem != '0)) begin
                  res_valid            = 1'b1;
                  res_item.record_code = code_in;
                  res_item.record_size = SIZE_W'(acc_in);
                  if (ovf_in || acc_in > rem) begin
                     res_item.kind = KIND_TRUNC;
                     phase_in      = (rem != '0) ? PHASE_DISCARD : PHASE_CODE;
                  end else begin
                     res_item.kind           = KIND_HEADER;
                     res_item.last_of_record = (acc_in == '0);
                     if (acc_in == '0) begin
                        phase_in = PHASE_CODE;
                     end else begin
                        pay_left_in = acc_in;
                        phase_in    = PHASE_PAYLOAD;
                     end
                  end
               end
            end
            PHASE_PAYLOAD: begin
               res_valid               = 1'b1;
               res_item.kind           = KIND_PAYLOAD;
               res_item.record_code    = code_in;
               res_item.record_size    = SIZE_W'(acc_in);
               res_item.payload_byte   = item.data_byte;
               res_item.last_of_record = (pay_left_in <= CW'(1));
               if (pay_left_in <= CW'(1)) begin
                  pay_left_in = '0;
                  phase_in    = PHASE_CODE;
               end else begin
                  pay_left_in = pay_left_in - CW'(1);
               end
            end
            default: begin
               if (rem == '0) begin
                  phase_in = PHASE_CODE;
               end
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### hdl/varint_record_deframer.sv
// Varint record deframer top level: input register, parser core, result register.
// Depends on vrd_pkg and vrd_core.
//
// Takes one packet byte per cycle unless req_stall is high and splits each packet into
// records (code byte, big-endian base-128 length, payload), giving a header item, one
// item per payload byte, or a junk/truncated error item. Every byte passes through an
// input register, combinational parse logic and a result register before its result
// item shows on rsp_valid, and a new byte can be accepted while the last one is being
// parsed; req_stall rises only while the result register is full and stalled.
`default_nettype none
module varint_record_deframer #(
   parameter int MAX_PACKET = vrd_pkg::MAX_PACKET_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire vrd_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output vrd_pkg::rsp_type      rsp_item
);
   import vrd_pkg::*;

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;
   logic    out_free;
   logic    step_en;
   logic    res_valid;
   rsp_type res_item;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step_en && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && step_en && res_valid) begin
         rsp_item_ff <= res_item;
      end
   end

   vrd_core #(
      .MAX_PACKET(MAX_PACKET)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .item     (in_item_ff),
      .res_valid(res_valid),
      .res_item (res_item)
   );

endmodule
`default_nettype wire

### tb/vrd_result_checker.sv
// Result checker for the varint record deframer: watches both channels, predicts
// the header, payload and error items from accepted packet bytes, compares them.
// Depends on vrd_pkg; reports outstanding, failed and matched counts to the bench.
module vrd_result_checker #(
   parameter int MAX_PACKET = vrd_pkg::MAX_PACKET_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire vrd_pkg::req_type req_item,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire vrd_pkg::rsp_type rsp_item,
   output int                    pending,
   output int                    errors,
   output int                    checked
);
   import vrd_pkg::*;

   int          frame_left;
   phase_type   parse_phase;
   logic [7:0]  rec_code;
   int          len_acc;
   bit          len_ovf;
   int          pay_left;
   rsp_type     expected_records[$];

   task automatic push_expect(input kind_type k, input logic [7:0] c, input int sz,
                              input logic [7:0] b, input bit l);
      rsp_type e;
      e.kind           = k;
      e.record_code    = c;
      e.record_size    = sz[SIZE_W-1:0];
      e.payload_byte   = b;
      e.last_of_record = l;
      expected_records.push_back(e);
   endtask

   task automatic parse_byte(input req_type r);
      int rem;
      int acc;
      bit last;
      if (r.start_of_packet) begin
         frame_left  = (r.packet_length > MAX_PACKET) ? MAX_PACKET : r.packet_length;
         parse_phase = PHASE_CODE;
         len_acc     = 0;
         len_ovf     = 0;
         pay_left    = 0;
      end
      if (frame_left == 0) return;
      rem        = frame_left - 1;
      frame_left = rem;
      case (parse_phase)
         PHASE_CODE: begin
            if (rem < 1) begin
               push_expect(KIND_JUNK, 8'h00, 0, 8'h00, 1'b0);
            end else begin
               rec_code    = r.data_byte;
               len_acc     = 0;
               len_ovf     = 0;
               parse_phase = PHASE_LENGTH;
            end
         end
         PHASE_LENGTH: begin
            acc = len_acc;
            if (!len_ovf) begin
               acc = (acc << GROUP_W) | int'(r.data_byte[6:0]);
               if (acc > MAX_PACKET) begin
                  len_ovf = 1'b1;
                  acc     = MAX_PACKET + 1;
               end
            end
            len_acc = acc;
            if (r.data_byte[7] && rem != 0) return;
            if (len_ovf || acc > rem) begin
               push_expect(KIND_TRUNC, rec_code, acc, 8'h00, 1'b0);
               parse_phase = (rem != 0) ? PHASE_DISCARD : PHASE_CODE;
            end else begin
               push_expect(KIND_HEADER, rec_code, acc, 8'h00, acc == 0);
               if (acc == 0) begin
                  parse_phase = PHASE_CODE;
               end else begin
                  pay_left    = acc;
                  parse_phase = PHASE_PAYLOAD;
               end
            end
         end
         PHASE_PAYLOAD: begin
            last = (pay_left <= 1);
            push_expect(KIND_PAYLOAD, rec_code, len_acc, r.data_byte, last);
            if (last) begin
               pay_left    = 0;
               parse_phase = PHASE_CODE;
            end else begin
               pay_left = pay_left - 1;
            end
         end
         default: begin
            if (rem == 0) parse_phase = PHASE_CODE;
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         frame_left  = 0;
         parse_phase = PHASE_CODE;
         rec_code    = 8'h00;
         len_acc     = 0;
         len_ovf     = 0;
         pay_left    = 0;
         expected_records.delete();
         errors      = 0;
         checked     = 0;
      end else begin
         if (req_valid && !req_stall) parse_byte(req_item);
         if (rsp_valid && !rsp_stall) begin
            if (expected_records.size() == 0) begin
               errors++;
               $display({"%0t: unexpected item, expected none, ",
                         "got kind %0d code %h size %0d byte %h last %b"},
                        $time, rsp_item.kind, rsp_item.record_code, rsp_item.record_size,
                        rsp_item.payload_byte, rsp_item.last_of_record);
            end else begin
               want = expected_records.pop_front();
               checked++;
               compare_field("kind", want.kind, rsp_item.kind);
               compare_field("record_code", want.record_code, rsp_item.record_code);
               compare_field("record_size", want.record_size, rsp_item.record_size);
               compare_field("payload_byte", want.payload_byte, rsp_item.payload_byte);
               compare_field("last_of_record", want.last_of_record,
                             rsp_item.last_of_record);
            end
         end
      end
      pending <= expected_records.size();
   end

endmodule

### tb/tb_top.sv
// Bench top for the varint record deframer: clock, reset, packet byte stimulus,
// random idling on both channels and the verdict. Depends on vrd_pkg,
// varint_record_deframer and vrd_result_checker.
module tb_top;
   import vrd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   int pending;
   int errors;
   int checked;
   int send_idle_pct;
   int stall_pct;
   int hold_left;
   int packet_bytes;
   int total_items;
   int cycle_count;

   varint_record_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   vrd_result_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .pending   (pending),
      .errors    (errors),
      .checked   (checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[varint_record_deframer] ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] d, input bit sop, input int len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_item  <= '{data_byte: d, start_of_packet: sop, packet_length: len[SIZE_W-1:0]};
      req_valid <= 1'b1;
      total_items++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_packet(input logic [7:0] bytes[$], input int declared);
      foreach (bytes[i])
         send_byte(bytes[i], i == 0, (i == 0) ? declared : $urandom_range(16383));
      packet_bytes += bytes.size();
   endtask

   // code byte, big-endian base-128 length, payload
   task automatic build_record(inout logic [7:0] pkt[$]);
      int         size;
      int         rest;
      logic [7:0] grp[$];
      size = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(12);
      rest = size;
      pkt.push_back(8'($urandom_range(255)));
      do begin
         grp.push_front(8'(rest % 128));
         rest = rest / 128;
      end while (rest > 0);
      if ($urandom_range(7) == 0) grp.push_front(8'h00);
      for (int i = 0; i < grp.size() - 1; i++) grp[i][7] = 1'b1;
      foreach (grp[i]) pkt.push_back(grp[i]);
      repeat (size) pkt.push_back(8'($urandom_range(255)));
   endtask

   initial begin
      logic [7:0] pkt[$];
      int         declared;
      int         sel;
      int         idle_tab[4];
      int         stall_tab[4];
      idle_tab      = '{0, 78, 0, 11};
      stall_tab     = '{0, 0, 78, 11};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = 0;
      packet_bytes  = 0;
      total_items   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // byte outside a packet, empty packet, lone junk byte
      send_byte(8'hFF, 1'b0, 16383);
      send_byte(8'h00, 1'b1, 0);
      send_byte(8'hAA, 1'b1, 1);
      // empty record, length cut off nonzero, length cut off at zero
      send_byte(8'hFF, 1'b1, 2);
      send_byte(8'h00, 1'b0, 0);
      send_byte(8'h12, 1'b1, 2);
      send_byte(8'h85, 1'b0, 0);
      send_byte(8'h34, 1'b1, 2);
      send_byte(8'h80, 1'b0, 0);
      // two payload bytes then a trailing junk byte
      send_byte(8'h00, 1'b1, 5);
      send_byte(8'h02, 1'b0, 0);
      send_byte(8'hFF, 1'b0, 0);
      send_byte(8'h00, 1'b0, 0);
      send_byte(8'h5A, 1'b0, 0);
      // oversized length, rest of packet dropped
      send_byte(8'h07, 1'b1, 6);
      send_byte(8'hFF, 1'b0, 0);
      send_byte(8'hFF, 1'b0, 0);
      send_byte(8'h7F, 1'b0, 0);
      send_byte(8'h11, 1'b0, 0);
      send_byte(8'h22, 1'b0, 0);
      // clamped packet length, abandoned mid-record by a new packet
      send_byte(8'h3C, 1'b1, 16383);
      send_byte(8'h83, 1'b0, 0);
      send_byte(8'h00, 1'b0, 0);
      send_byte(8'h99, 1'b0, 0);
      send_byte(8'h55, 1'b1, 3);
      send_byte(8'h00, 1'b0, 0);
      send_byte(8'h01, 1'b0, 0);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_tab[ph];
         stall_pct     = stall_tab[ph];
         if (ph == 0) hold_left = 300;
         while (packet_bytes < (ph + 1) * 250) begin
            sel = $urandom_range(99);
            pkt = {};
            declared = 0;
            if (sel < 78) begin
               repeat ($urandom_range(1, 4)) build_record(pkt);
               declared = pkt.size();
               case ($urandom_range(11))
                  0: begin
                     repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(255)));
                     declared = pkt.size();
                  end
                  1: declared = $urandom_range(1, pkt.size());
                  2: declared = pkt.size() + $urandom_range(1, 5);
                  default: ;
               endcase
            end else if (sel < 86) begin
               pkt.push_back(8'($urandom_range(255)));
               pkt.push_back(8'h80 | 8'($urandom_range(1, 127)));
               pkt.push_back(8'h80 | 8'($urandom_range(127)));
               pkt.push_back(8'($urandom_range(127)));
               repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom_range(255)));
               declared = pkt.size();
            end else if (sel < 92) begin
               repeat ($urandom_range(1, 4))
                  send_byte(8'($urandom_range(255)), 1'b0, $urandom_range(16383));
            end else if (sel < 95) begin
               send_byte(8'($urandom_range(255)), 1'b1, 0);
            end else begin
               build_record(pkt);
               repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom_range(255)));
               declared = $urandom_range(8192, 16383);
            end
            if (pkt.size() > 0) send_packet(pkt, declared);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Drove %0d bytes (%0d in random packets) through four idling phases",
               total_items, packet_bytes);
      $display("and one long result hold-off; %0d result items compared.", checked);
      if (errors == 0 && pending == 0) begin
         $display("[varint_record_deframer] OK");
      end else begin
         $display("[varint_record_deframer] ERROR");
      end
      $finish;
   end

endmodule
